@@ sv/pip_pkg.sv @@
// ---------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon crossing-number test.
// ---------------------------------------------------------------------------
package pip_pkg;

    // per-item control carried from the front to the back
    typedef struct packed {
        logic start;    // first vertex of a polygon, parity starts over
        logic edge_en;  // edge from previous vertex to this vertex exists
        logic last;     // final vertex, closing edge and result
        logic few;      // polygon ended with fewer than three vertices
    } pip_flags_t;

    localparam int FLAGS_W = $bits(pip_flags_t);

    localparam logic [1:0] SEEN_SAT = 2'd3;
    localparam logic [1:0] SEEN_FEW = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    // coordinate slots in a queued item
    localparam int COORD_SLOTS = 8;

endpackage

@@ sv/pip_front.sv @@
// ---------------------------------------------------------------------------
// pip_front
// Accepts vertex items, keeps the query point, first and previous vertex and
// the vertex count, and hands each item with its edge coordinates onward.
// ---------------------------------------------------------------------------
module pip_front
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [COORD_WIDTH-1:0]        point_x,
    input  logic signed [COORD_WIDTH-1:0]        point_y,
    input  logic signed [COORD_WIDTH-1:0]        vertex_x,
    input  logic signed [COORD_WIDTH-1:0]        vertex_y,
    input  logic                                 last_vertex,
    output logic                                 job_valid,
    input  logic                                 job_ready,
    output pip_flags_t                           job_flags,
    output logic [COORD_SLOTS*COORD_WIDTH-1:0]   job_coords
);

    logic signed [COORD_WIDTH-1:0] query_x_reg, query_x_next;
    logic signed [COORD_WIDTH-1:0] query_y_reg, query_y_next;
    logic signed [COORD_WIDTH-1:0] first_x_reg, first_x_next;
    logic signed [COORD_WIDTH-1:0] first_y_reg, first_y_next;
    logic signed [COORD_WIDTH-1:0] prev_x_reg, prev_x_next;
    logic signed [COORD_WIDTH-1:0] prev_y_reg, prev_y_next;
    logic [1:0]                    seen_count_reg, seen_count_next;
    logic                          accept;
    logic                          new_poly;

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign accept    = in_valid && job_ready;
    assign new_poly  = (seen_count_reg == 2'd0);

    always_comb
    begin
        job_flags.start   = new_poly;
        job_flags.edge_en = !new_poly;
        job_flags.last    = last_vertex;
        job_flags.few     = last_vertex && (seen_count_reg < SEEN_FEW);
    end

    // query, previous, current, first
    assign job_coords = {query_x_reg, query_y_reg, prev_x_reg, prev_y_reg,
                         vertex_x, vertex_y, first_x_reg, first_y_reg};

    always_comb
    begin
        query_x_next    = query_x_reg;
        query_y_next    = query_y_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        seen_count_next = seen_count_reg;
        if (accept)
        begin
            if (new_poly)
            begin
                query_x_next = point_x;
                query_y_next = point_y;
                first_x_next = vertex_x;
                first_y_next = vertex_y;
            end
            prev_x_next = vertex_x;
            prev_y_next = vertex_y;
            if (last_vertex)
                seen_count_next = 2'd0;
            else if (seen_count_reg != SEEN_SAT)
                seen_count_next = seen_count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x_reg    <= '0;
            query_y_reg    <= '0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            seen_count_reg <= 2'd0;
        end
        else
        begin
            query_x_reg    <= query_x_next;
            query_y_reg    <= query_y_next;
            first_x_reg    <= first_x_next;
            first_y_reg    <= first_y_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            seen_count_reg <= seen_count_next;
        end
    end

endmodule

@@ sv/pip_queue.sv @@
// ---------------------------------------------------------------------------
// pip_queue
// Short first-in first-out queue between the front and the back.
// ---------------------------------------------------------------------------
module pip_queue
    import pip_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/pip_back.sv @@
// ---------------------------------------------------------------------------
// pip_back
// Edge crossing tests: straddle checks and cross products in one stage,
// product compares and parity update in the next, then the result register.
// ---------------------------------------------------------------------------
module pip_back
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 job_valid,
    output logic                                 job_ready,
    input  pip_flags_t                           job_flags,
    input  logic [COORD_SLOTS*COORD_WIDTH-1:0]   job_coords,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 inside_res,
    output logic                                 too_few_vertices
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * COORD_WIDTH + 2;

    logic signed [W-1:0]  qx, qy, px, py, vx, vy, fx, fy;

    // edge a: previous to current, edge b: current back to first
    logic signed [DW-1:0] a_dy, a_dqx, a_dx, a_dqy;
    logic signed [DW-1:0] b_dy, b_dqx, b_dx, b_dqy;
    logic                 a_straddle, b_straddle;

    logic signed [PW-1:0] a_p1_reg, a_p1_next, a_p2_reg, a_p2_next;
    logic signed [PW-1:0] b_p1_reg, b_p1_next, b_p2_reg, b_p2_next;
    logic                 a_dpos_reg, a_dpos_next, b_dpos_reg, b_dpos_next;
    logic                 a_hit_reg, a_hit_next, b_hit_reg, b_hit_next;
    pip_flags_t           s1_flags_reg, s1_flags_next;
    logic                 s1_valid_reg, s1_valid_next;

    logic                 parity_reg, parity_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 inside_reg, inside_next;
    logic                 few_reg, few_next;

    logic                 s1_drain;
    logic                 s1_load;
    logic                 a_left, b_left;
    logic                 parity_after;

    assign {qx, qy, px, py, vx, vy, fx, fy} = job_coords;

    always_comb
    begin
        a_straddle = (py > qy) != (vy > qy);
        b_straddle = (vy > qy) != (fy > qy);
        a_dy  = $signed({vy[W-1], vy}) - $signed({py[W-1], py});
        a_dqx = $signed({qx[W-1], qx}) - $signed({px[W-1], px});
        a_dx  = $signed({vx[W-1], vx}) - $signed({px[W-1], px});
        a_dqy = $signed({qy[W-1], qy}) - $signed({py[W-1], py});
        b_dy  = $signed({fy[W-1], fy}) - $signed({vy[W-1], vy});
        b_dqx = $signed({qx[W-1], qx}) - $signed({vx[W-1], vx});
        b_dx  = $signed({fx[W-1], fx}) - $signed({vx[W-1], vx});
        b_dqy = $signed({qy[W-1], qy}) - $signed({vy[W-1], vy});
    end

    assign a_p1_next   = a_dqx * a_dy;
    assign a_p2_next   = a_dx * a_dqy;
    assign b_p1_next   = b_dqx * b_dy;
    assign b_p2_next   = b_dx * b_dqy;
    assign a_dpos_next = (vy > py);
    assign b_dpos_next = (fy > vy);
    assign a_hit_next  = a_straddle && job_flags.edge_en;
    assign b_hit_next  = b_straddle && job_flags.last && !job_flags.few;
    assign s1_flags_next = job_flags;

    // a result-bearing item leaves stage one only into a free result slot
    assign s1_drain  = s1_valid_reg &&
                       (!s1_flags_reg.last || !out_valid_reg || out_ready);
    assign s1_load   = !s1_valid_reg || s1_drain;
    assign job_ready = s1_load;

    assign a_left = a_dpos_reg ? (a_p1_reg < a_p2_reg) : (a_p2_reg < a_p1_reg);
    assign b_left = b_dpos_reg ? (b_p1_reg < b_p2_reg) : (b_p2_reg < b_p1_reg);

    always_comb
    begin
        parity_after   = (s1_flags_reg.start ? 1'b0 : parity_reg)
                         ^ (a_hit_reg && a_left) ^ (b_hit_reg && b_left);
        s1_valid_next  = s1_load ? job_valid : s1_valid_reg;
        parity_next    = parity_reg;
        out_valid_next = out_valid_reg;
        inside_next    = inside_reg;
        few_next       = few_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (s1_drain)
        begin
            if (s1_flags_reg.last)
            begin
                parity_next    = 1'b0;
                out_valid_next = 1'b1;
                inside_next    = parity_after && !s1_flags_reg.few;
                few_next       = s1_flags_reg.few;
            end
            else
            begin
                parity_next = parity_after;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            a_p1_reg     <= a_p1_next;
            a_p2_reg     <= a_p2_next;
            b_p1_reg     <= b_p1_next;
            b_p2_reg     <= b_p2_next;
            a_dpos_reg   <= a_dpos_next;
            b_dpos_reg   <= b_dpos_next;
            a_hit_reg    <= a_hit_next;
            b_hit_reg    <= b_hit_next;
            s1_flags_reg <= s1_flags_next;
        end
        inside_reg <= inside_next;
        few_reg    <= few_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            parity_reg    <= parity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign inside_res       = inside_reg;
    assign too_few_vertices = few_reg;

    a_few_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(few_reg && inside_reg))
        else $error("short polygon reported inside");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_drain && s1_flags_reg.last) |=> out_valid_reg)
        else $error("final vertex drained without a result");

    a_parity_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_drain && s1_flags_reg.last) |=> (parity_reg == 1'b0))
        else $error("parity not cleared after a result");

endmodule

@@ sv/point_in_polygon_test.sv @@
// ---------------------------------------------------------------------------
// point_in_polygon_test
// Crossing-number point-in-polygon test over a streamed polygon.
// ---------------------------------------------------------------------------
// Vertices are taken one item per clock cycle while the queue has room,
// in polygon order, with the query point read on each polygon's first item;
// the item with last_vertex set closes the polygon back to its first vertex
// and yields one result. Items pass from the vertex front end through a
// two-entry queue into a back end of one multiplier stage (four signed
// products of the edge differences) and one compare stage that updates the
// crossing parity, followed by the result register. A result that is not
// taken stalls only the back end; the front keeps taking vertices until the
// queue fills.
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] vertex_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_y,
    input  logic                          last_vertex,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          inside_res,
    output logic                          too_few_vertices
);

    localparam int COORDS_W = COORD_SLOTS * COORD_WIDTH;
    localparam int JOB_W    = FLAGS_W + COORDS_W;

    logic                 front_valid;
    logic                 front_ready;
    pip_flags_t           front_flags;
    logic [COORDS_W-1:0]  front_coords;
    logic                 back_valid;
    logic                 back_ready;
    logic [JOB_W-1:0]     back_job;
    pip_flags_t           back_flags;
    logic [COORDS_W-1:0]  back_coords;

    pip_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .last_vertex (last_vertex),
        .job_valid   (front_valid),
        .job_ready   (front_ready),
        .job_flags   (front_flags),
        .job_coords  (front_coords)
    );

    pip_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  ({front_flags, front_coords}),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_job)
    );

    assign back_flags  = back_job[JOB_W-1:COORDS_W];
    assign back_coords = back_job[COORDS_W-1:0];

    pip_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .job_valid        (back_valid),
        .job_ready        (back_ready),
        .job_flags        (back_flags),
        .job_coords       (back_coords),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .inside_res       (inside_res),
        .too_few_vertices (too_few_vertices)
    );

endmodule

@@ sim/point_in_polygon_test_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// point_in_polygon_test_test
// Streams polygons into the crossing-number test and checks every verdict.
// ---------------------------------------------------------------------------
// A scoreboard keeps its own parity and vertex count per polygon and works
// out the expected verdict with exact signed products. Directed polygons
// cover degenerate sizes, extreme coordinates, horizontal edges and a query
// point on a vertex. Random polygons follow, mostly clustered around the
// query point so that crossings happen, with random gaps on the input,
// random stalls on the output and one long output stall.
// ---------------------------------------------------------------------------
module point_in_polygon_test_test
    import pip_pkg::*;
();

    localparam int CW          = 16;
    localparam int N_ITEMS     = 650;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;
    localparam int HOLD_CYCLES = 300;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic in_poly;
        logic few;
    } verdict_t;

    class polygon_scoreboard;
        coord_t     query_x, query_y, first_x, first_y, prev_x, prev_y;
        bit         parity;
        logic [1:0] seen;
        verdict_t   verdict_q[$];
        int         errors;

        function new();
            query_x = '0;
            query_y = '0;
            first_x = '0;
            first_y = '0;
            prev_x  = '0;
            prev_y  = '0;
            parity  = 1'b0;
            seen    = '0;
            errors  = 0;
        endfunction

        // one edge: toggles parity when the point is left of its crossing
        function void cross_edge(coord_t x1, coord_t y1, coord_t x2, coord_t y2);
            longint d, lhs, rhs;
            bit     left;
            if ((y1 > query_y) == (y2 > query_y))
                return;
            d    = longint'(y2) - longint'(y1);
            lhs  = (longint'(query_x) - longint'(x1)) * d;
            rhs  = (longint'(x2) - longint'(x1)) * (longint'(query_y) - longint'(y1));
            left = (d > 0) ? (lhs < rhs) : (lhs > rhs);
            if (left)
                parity = ~parity;
        endfunction

        function void note_vertex(coord_t px, coord_t py, coord_t vx, coord_t vy,
                                  logic last);
            verdict_t v;
            if (seen == 0)
            begin
                query_x = px;
                query_y = py;
                first_x = vx;
                first_y = vy;
                parity  = 1'b0;
            end
            else
            begin
                cross_edge(prev_x, prev_y, vx, vy);
            end
            prev_x = vx;
            prev_y = vy;
            if (seen != SEEN_SAT)
                seen = seen + 1'b1;
            if (last)
            begin
                if (seen != SEEN_SAT)
                begin
                    v.in_poly = 1'b0;
                    v.few     = 1'b1;
                end
                else
                begin
                    cross_edge(vx, vy, first_x, first_y);
                    v.in_poly = parity;
                    v.few     = 1'b0;
                end
                verdict_q.insert(verdict_q.size(), v);
                seen   = '0;
                parity = 1'b0;
            end
        endfunction

        function void check_verdict(logic in_poly, logic few);
            verdict_t exp_v;
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected result inside_res=%0b too_few_vertices=%0b",
                         $time, in_poly, few);
                errors++;
                return;
            end
            exp_v = verdict_q.pop_front();
            if (in_poly !== exp_v.in_poly)
            begin
                $display("%0t: inside_res expected %0b got %0b",
                         $time, exp_v.in_poly, in_poly);
                errors++;
            end
            if (few !== exp_v.few)
            begin
                $display("%0t: too_few_vertices expected %0b got %0b",
                         $time, exp_v.few, few);
                errors++;
            end
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    coord_t point_x;
    coord_t point_y;
    coord_t vertex_x;
    coord_t vertex_y;
    logic   last_vertex;
    logic   out_valid;
    logic   out_ready;
    logic   inside_res;
    logic   too_few_vertices;

    polygon_scoreboard sb = new();
    int  items_sent   = 0;
    int  cycle_count  = 0;
    bit  hold_off_req = 1'b0;

    point_in_polygon_test #(.COORD_WIDTH(CW)) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .point_x          (point_x),
        .point_y          (point_y),
        .vertex_x         (vertex_x),
        .vertex_y         (vertex_y),
        .last_vertex      (last_vertex),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .inside_res       (inside_res),
        .too_few_vertices (too_few_vertices)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // handshakes are sampled on the falling edge ahead of the rising edge that takes them
    always @(negedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_vertex(point_x, point_y, vertex_x, vertex_y, last_vertex);
        if (rst_n && out_valid && out_ready)
            sb.check_verdict(inside_res, too_few_vertices);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic coord_t rand_full();
        return coord_t'($urandom);
    endfunction

    function automatic int spread_of(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // output side: ready bursts, random stalls and one long hold-off
    initial
    begin
        int run_len;
        int stall_len;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            run_len = $urandom_range(1, 60);
            out_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            stall_len = pick_gap();
            if (stall_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    task automatic send_vertex(coord_t px, coord_t py, coord_t vx, coord_t vy,
                               logic last, bit quiet);
        int gap;
        point_x     <= px;
        point_y     <= py;
        vertex_x    <= vx;
        vertex_y    <= vy;
        last_vertex <= last;
        in_valid    <= 1'b1;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        items_sent++;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // query point goes with the first item; later items carry noise there
    task automatic send_polygon(coord_t qx, coord_t qy, coord_t xs[$], coord_t ys[$],
                                bit quiet);
        coord_t px, py;
        for (int i = 0; i < xs.size(); i++)
        begin
            px = (i == 0) ? qx : rand_full();
            py = (i == 0) ? qy : rand_full();
            send_vertex(px, py, xs[i], ys[i], i == xs.size() - 1, quiet);
        end
    endtask

    initial
    begin
        coord_t xs[$];
        coord_t ys[$];
        coord_t qx, qy;
        int     n, r, cx, cy, span, k;
        bit     quiet, grid;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        point_x     <= '0;
        point_y     <= '0;
        vertex_x    <= '0;
        vertex_y    <= '0;
        last_vertex <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // single vertex, then two vertices
        xs = '{coord_t'(32767)};
        ys = '{coord_t'(-32768)};
        send_polygon(coord_t'(0), coord_t'(0), xs, ys, 1'b1);
        xs = '{coord_t'(-32768), coord_t'(32767)};
        ys = '{coord_t'(32767), coord_t'(-32768)};
        send_polygon(coord_t'(-1), coord_t'(1), xs, ys, 1'b0);

        // triangle with the point inside, then outside
        xs = '{coord_t'(-160), coord_t'(160), coord_t'(0)};
        ys = '{coord_t'(-160), coord_t'(-160), coord_t'(160)};
        send_polygon(coord_t'(0), coord_t'(0), xs, ys, 1'b1);
        send_polygon(coord_t'(320), coord_t'(0), xs, ys, 1'b1);

        // full-range square, point at the center and on a corner
        xs = '{coord_t'(-32768), coord_t'(32767), coord_t'(32767), coord_t'(-32768)};
        ys = '{coord_t'(-32768), coord_t'(-32768), coord_t'(32767), coord_t'(32767)};
        send_polygon(coord_t'(0), coord_t'(0), xs, ys, 1'b0);
        send_polygon(coord_t'(-32768), coord_t'(-32768), xs, ys, 1'b1);

        // concave polygon with horizontal edges, point level with a vertex
        xs = '{coord_t'(-160), coord_t'(160), coord_t'(160),
               coord_t'(0), coord_t'(-160), coord_t'(-160)};
        ys = '{coord_t'(-160), coord_t'(-160), coord_t'(160),
               coord_t'(0), coord_t'(160), coord_t'(160)};
        send_polygon(coord_t'(-80), coord_t'(0), xs, ys, 1'b1);

        hold_off_req = 1'b1;

        while (items_sent < N_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                n = $urandom_range(1, 2);
            else if (r < 85)
                n = $urandom_range(3, 8);
            else
                n = $urandom_range(9, 20);
            quiet = ($urandom_range(0, 3) == 0);
            xs.delete();
            ys.delete();
            if ($urandom_range(0, 3) == 0)
            begin
                qx = rand_full();
                qy = rand_full();
                for (int i = 0; i < n; i++)
                begin
                    xs.insert(xs.size(), rand_full());
                    ys.insert(ys.size(), rand_full());
                end
            end
            else
            begin
                cx   = int'($urandom_range(0, 32000)) - 16000;
                cy   = int'($urandom_range(0, 32000)) - 16000;
                span = $urandom_range(4, 4000);
                grid = ($urandom_range(0, 4) == 0);
                for (int i = 0; i < n; i++)
                begin
                    if (grid)
                    begin
                        xs.insert(xs.size(), coord_t'((cx + spread_of(span)) & ~255));
                        ys.insert(ys.size(), coord_t'((cy + spread_of(span)) & ~255));
                    end
                    else
                    begin
                        xs.insert(xs.size(), coord_t'(cx + spread_of(span)));
                        ys.insert(ys.size(), coord_t'(cy + spread_of(span)));
                    end
                end
                qx = coord_t'(cx + spread_of(span / 2));
                qy = coord_t'(cy + spread_of(span / 2));
                if (grid)
                begin
                    qx = coord_t'(int'(qx) & ~255);
                    qy = coord_t'(int'(qy) & ~255);
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    k  = $urandom_range(0, n - 1);
                    qx = xs[k];
                    qy = ys[k];
                end
            end
            send_polygon(qx, qy, xs, ys, quiet);
        end
        in_valid <= 1'b0;

        while (sb.verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sim.f @@
sv/pip_pkg.sv
sv/pip_front.sv
sv/pip_queue.sv
sv/pip_back.sv
sv/point_in_polygon_test.sv
sim/point_in_polygon_test_test.sv
